[rtl/core/prsd_pkg.sv]
// Shared types and codes for the packed record stream decoder.
package prsd_pkg;

  typedef enum logic [1:0] {
    PH_COUNT  = 2'd0,
    PH_HEADER = 2'd1,
    PH_STRING = 2'd2,
    PH_INT    = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    FT_STRING   = 2'd0,
    FT_SIGNED   = 2'd1,
    FT_UNSIGNED = 2'd2
  } ftype_t;

  typedef enum logic [2:0] {
    KIND_COUNT = 3'd0,
    KIND_CHAR  = 3'd1,
    KIND_EMPTY = 3'd2,
    KIND_SINT  = 3'd3,
    KIND_UINT  = 3'd4
  } kind_t;

  localparam logic [7:0] LAST_FIELD_BIT = 8'h80;
  localparam logic [7:0] STRING_BIT     = 8'h40;
  localparam logic [7:0] STR_LEN_MASK   = 8'h3F;
  localparam logic [7:0] SIGNED_BIT     = 8'h20;
  localparam logic [7:0] INT_LEN_MASK   = 8'h1F;

  typedef struct packed {
    phase_t      phase;
    logic [7:0]  records_left;
    logic [5:0]  bytes_left;
    logic [4:0]  total_bytes;
    ftype_t      ftype;
    logic        final_field;
    logic [31:0] acc;
  } dec_state_t;

  typedef struct packed {
    kind_t       kind;
    logic [31:0] value;
    logic        field_done;
    logic        record_done;
    logic        stream_done;
  } dec_result_t;

endpackage

[rtl/core/packed_record_stream_decoder_unit.sv]
// Top level of the packed record stream decoder: state registers and result register.
// The block decodes a record stream one byte per request and accepts a byte in every
// cycle while the result register is empty or being drained; a result appears in the
// cycle after the byte that causes it. The first byte of a stream is the record count,
// then each field has a header byte followed by its string or big-endian integer bytes.
// Every string byte, every count byte, every finished integer and every zero-length field
// gives one result; other integer bytes and non-empty headers give none. The single result
// register sets the rate: while it holds a result that is stalled, no byte is taken.
module packed_record_stream_decoder_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_stream_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_item_kind,
  output logic [31:0] out_item_value,
  output logic        out_field_done,
  output logic        out_record_done,
  output logic        out_stream_done
);
  import prsd_pkg::*;

  dec_state_t  state_r;
  dec_state_t  state_nxt;
  dec_result_t res_nxt;
  dec_result_t res_r;
  logic        res_vld_nxt;
  logic        out_valid_r;
  logic        in_acc;
  logic        out_acc;

  assign in_stall = out_valid_r && out_stall;
  assign in_acc   = in_valid && !in_stall;
  assign out_acc  = out_valid_r && !out_stall;

  prsd_decode u_decode (
    .state_i     (state_r),
    .byte_i      (in_stream_byte),
    .state_o     (state_nxt),
    .res_valid_o (res_vld_nxt),
    .res_o       (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.phase        <= PH_COUNT;
      state_r.records_left <= '0;
      state_r.bytes_left   <= '0;
      state_r.total_bytes  <= '0;
      state_r.ftype        <= FT_STRING;
      state_r.final_field  <= 1'b0;
      state_r.acc          <= '0;
      out_valid_r          <= 1'b0;
    end else begin
      if (in_acc) begin
        state_r <= state_nxt;
      end
      if (in_acc) begin
        out_valid_r <= res_vld_nxt;
      end else if (out_acc) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && res_vld_nxt) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_item_kind   = res_r.kind;
  assign out_item_value  = res_r.value;
  assign out_field_done  = res_r.field_done;
  assign out_record_done = res_r.record_done;
  assign out_stream_done = res_r.stream_done;

  // After reset the decoder waits for a count byte with nothing to deliver.
  a_reset_state: assert property (@(posedge clk)
    !rst_n |=> (state_r.phase == PH_COUNT) && !out_valid_r)
    else $error("decoder not idle after reset");

  a_record_needs_field: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && res_r.record_done |-> res_r.field_done)
    else $error("record completed without a field");

  a_stream_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && res_r.stream_done |->
      res_r.record_done || (res_r.kind == KIND_COUNT && res_r.value == 32'd0))
    else $error("stream end flagged without a closing record or zero count");

  a_stream_end_phase: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && res_vld_nxt && res_nxt.stream_done |=> state_r.phase == PH_COUNT)
    else $error("stream ended but next byte not taken as a count");

  a_count_no_field: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && res_r.kind == KIND_COUNT |-> !res_r.field_done)
    else $error("count result marked as field end");

endmodule

[rtl/core/prsd_decode.sv]
// Combinational next-state and result logic for one stream byte.
module prsd_decode (
  input  prsd_pkg::dec_state_t  state_i,
  input  logic [7:0]            byte_i,
  output prsd_pkg::dec_state_t  state_o,
  output logic                  res_valid_o,
  output prsd_pkg::dec_result_t res_o
);
  import prsd_pkg::*;

  always_comb begin
    logic [5:0]  bl;
    logic [31:0] acc_n;
    logic [7:0]  rl;
    logic        fin;

    state_o     = state_i;
    res_valid_o = 1'b0;
    res_o       = '0;
    fin         = 1'b0;
    bl          = state_i.bytes_left - 6'd1;
    acc_n       = {state_i.acc[23:0], byte_i};
    rl          = state_i.records_left - 8'd1;

    case (state_i.phase)
      PH_COUNT: begin
        state_o.records_left = byte_i;
        state_o.phase        = (byte_i != 8'd0) ? PH_HEADER : PH_COUNT;
        res_valid_o          = 1'b1;
        res_o.kind           = KIND_COUNT;
        res_o.value          = {24'd0, byte_i};
        res_o.stream_done    = (byte_i == 8'd0);
      end
      PH_HEADER: begin
        state_o.final_field = |(byte_i & LAST_FIELD_BIT);
        if (|(byte_i & STRING_BIT)) begin
          state_o.ftype = FT_STRING;
          if ((byte_i & STR_LEN_MASK) == 8'd0) begin
            fin        = 1'b1;
            res_o.kind = KIND_EMPTY;
          end else begin
            state_o.bytes_left = byte_i[5:0];
            state_o.phase      = PH_STRING;
          end
        end else begin
          state_o.ftype       = (|(byte_i & SIGNED_BIT)) ? FT_SIGNED : FT_UNSIGNED;
          state_o.total_bytes = byte_i[4:0];
          state_o.acc         = '0;
          if ((byte_i & INT_LEN_MASK) == 8'd0) begin
            fin        = 1'b1;
            res_o.kind = (|(byte_i & SIGNED_BIT)) ? KIND_SINT : KIND_UINT;
          end else begin
            state_o.bytes_left = {1'b0, byte_i[4:0]};
            state_o.phase      = PH_INT;
          end
        end
      end
      PH_STRING: begin
        state_o.bytes_left = bl;
        res_o.kind         = KIND_CHAR;
        res_o.value        = {24'd0, byte_i};
        if (bl == 6'd0) begin
          fin = 1'b1;
        end else begin
          res_valid_o = 1'b1;
        end
      end
      PH_INT: begin
        state_o.acc        = acc_n;
        state_o.bytes_left = bl;
        if (bl == 6'd0) begin
          fin         = 1'b1;
          res_o.value = acc_n;
          if (state_i.ftype == FT_SIGNED) begin
            res_o.kind = KIND_SINT;
            // Short signed values are widened only when their top bit is set.
            case (state_i.total_bytes)
              5'd1:    if (acc_n[7])  res_o.value[31:8]  = '1;
              5'd2:    if (acc_n[15]) res_o.value[31:16] = '1;
              5'd3:    if (acc_n[23]) res_o.value[31:24] = '1;
              default: ;
            endcase
          end else begin
            res_o.kind = KIND_UINT;
          end
        end
      end
      default: ;
    endcase

    // A completed field closes the record when its header marked it last, and the stream when that was the last record.
    if (fin) begin
      res_valid_o      = 1'b1;
      res_o.field_done = 1'b1;
      if (state_o.final_field) begin
        res_o.record_done    = 1'b1;
        state_o.records_left = rl;
        if (rl == 8'd0) begin
          res_o.stream_done = 1'b1;
          state_o.phase     = PH_COUNT;
        end else begin
          state_o.phase = PH_HEADER;
        end
      end else begin
        state_o.phase = PH_HEADER;
      end
    end
  end

endmodule
